// ----- hdl/sprite_xor_draw_with_collision_defines.svh -----
// assertion macros for the sprite draw block
`ifndef SPRITE_XOR_DRAW_WITH_COLLISION_DEFINES_SVH
`define SPRITE_XOR_DRAW_WITH_COLLISION_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, clocked on clk, off during reset
`define SXD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SXD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SXD_ASSERT_NOW(lbl, ante, cons, msg)

`define SXD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/sxd_pkg.sv -----
// shared types and constants for the sprite draw block
`default_nettype none

package sxd_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int SPRITE_W      = 8;

    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
    localparam int BYTES_PER_ROW = SCREEN_WIDTH / SPRITE_W;
    localparam int BSEL_W        = $clog2(BYTES_PER_ROW);
    localparam int TOTAL_BYTES   = BYTES_PER_ROW * SCREEN_HEIGHT;

    typedef enum logic
    {
        MODE_DRAW = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t      mode;
        logic [7:0] sprite_x;
        logic [7:0] sprite_y;
        logic [3:0] row_index;
        logic [7:0] row_pixels;
        logic [7:0] byte_index;
    } cmd_word_t;

    typedef struct packed
    {
        logic       collision;
        logic [7:0] read_byte;
    } result_word_t;

    typedef logic [SCREEN_WIDTH-1:0] row_t;

endpackage

`default_nettype wire

// ----- hdl/sprite_xor_draw_with_collision.sv -----
// top level: sprite row xor draw into a one-bit screen with collision flag
`default_nettype none
`include "sprite_xor_draw_with_collision_defines.svh"

// Takes one command word per clock (busy stays low) and answers each with one
// result word on result, marked by done for a single cycle, once the command has
// passed stage one and the result and done registers; results come back in
// command order and must be caught when shown. A draw does a read-modify-write
// of one 64-pixel screen row in a single-port-read, single-port-write row
// memory: the row is read at the accept edge and written back from stage one,
// and a command that reads the row being written in that same cycle gets the new
// contents by forwarding. The screen is blank right after reset: each row has a
// flag that reset clears, so no clearing pass is needed and the first command
// may follow reset at once.
module sprite_xor_draw_with_collision
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  sxd_pkg::cmd_word_t    cmd,
    output logic                  done,
    output sxd_pkg::result_word_t result
);
    import sxd_pkg::*;

    logic             accept;
    logic [ROW_W-1:0] rd_addr;
    logic             in_range;
    row_t             rd_data;

    logic              s1_valid_reg;
    cmd_word_t         s1_cmd_reg;
    logic [ROW_W-1:0]  s1_addr_reg;
    logic [BSEL_W-1:0] s1_bsel_reg;
    logic              s1_in_range_reg;

    row_t             mask;
    row_t             row_new;
    logic             hit;
    logic [COL_W-1:0] sel_base;
    logic [7:0]       byte_val;
    logic             wr_en;

    logic         collision_reg;
    logic         collision_next;
    logic         done_reg;
    result_word_t result_reg;
    result_word_t result_next;

    // every cycle can take a command
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // row to fetch: sprite row with vertical wrap, or the row holding the byte
    always_comb
    begin
        in_range = (int'(cmd.byte_index) < TOTAL_BYTES);
        if (cmd.mode == MODE_DRAW)
        begin
            rd_addr = ROW_W'((int'(cmd.sprite_y) + int'(cmd.row_index)) % SCREEN_HEIGHT);
        end
        else
        begin
            rd_addr = ROW_W'(int'(cmd.byte_index) / BYTES_PER_ROW);
        end
    end

    sxd_row_mem u_row_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (row_new)
    );

    // stage one: command waits for its row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= cmd;
            s1_addr_reg     <= rd_addr;
            s1_bsel_reg     <= BSEL_W'(int'(cmd.byte_index) % BYTES_PER_ROW);
            s1_in_range_reg <= in_range;
        end
    end

    // sprite mask with horizontal wrap, xor and collision test
    always_comb
    begin
        mask = '0;
        for (int b = 0; b < SPRITE_W; b++)
        begin
            if (s1_cmd_reg.row_pixels[SPRITE_W-1-b])
            begin
                mask[COL_W'((int'(s1_cmd_reg.sprite_x) + b) % SCREEN_WIDTH)] = 1'b1;
            end
        end
        hit     = |(rd_data & mask);
        row_new = rd_data ^ mask;
    end

    // packed byte pick, leftmost pixel in bit 7
    always_comb
    begin
        sel_base = {s1_bsel_reg, 3'b000};
        byte_val = '0;
        for (int b = 0; b < SPRITE_W; b++)
        begin
            byte_val[SPRITE_W-1-b] = rd_data[sel_base + COL_W'(b)];
        end
    end

    assign wr_en = s1_valid_reg && (s1_cmd_reg.mode == MODE_DRAW);

    // collision flag and result word
    always_comb
    begin
        collision_next        = collision_reg;
        result_next.read_byte = '0;
        if (s1_valid_reg)
        begin
            if (s1_cmd_reg.mode == MODE_DRAW)
            begin
                if (s1_cmd_reg.row_index == 4'd0)
                begin
                    collision_next = hit;
                end
                else
                begin
                    collision_next = collision_reg || hit;
                end
            end
            else if (s1_in_range_reg)
            begin
                result_next.read_byte = byte_val;
            end
        end
        result_next.collision = collision_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collision_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            collision_reg <= collision_next;
            done_reg      <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every taken command is answered with done after stage one and the done register
    `SXD_ASSERT_NOW(a_done_latency, accept, ##2 done, "command not answered in two cycles")
    // a draw never reports a display byte
    `SXD_ASSERT_NEXT(a_draw_byte_zero, s1_valid_reg && (s1_cmd_reg.mode == MODE_DRAW), result.read_byte == 8'd0, "draw result carries a byte")
    // a read leaves the collision flag alone
    `SXD_ASSERT_NEXT(a_read_keeps_flag, s1_valid_reg && (s1_cmd_reg.mode == MODE_READ), $stable(collision_reg), "read changed collision flag")
    // an empty first sprite row clears the flag
    `SXD_ASSERT_NEXT(a_empty_first_row, s1_valid_reg && (s1_cmd_reg.mode == MODE_DRAW) && (s1_cmd_reg.row_index == 4'd0) && (s1_cmd_reg.row_pixels == 8'd0), !collision_reg, "flag not cleared by empty first row")

endmodule

`default_nettype wire

// ----- hdl/sxd_row_mem.sv -----
// screen row memory with per-row valid flags and write-to-read bypass
`default_nettype none

module sxd_row_mem
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       rd_en,
    input  wire  [sxd_pkg::ROW_W-1:0] rd_addr,
    output sxd_pkg::row_t             rd_data,
    input  wire                       wr_en,
    input  wire  [sxd_pkg::ROW_W-1:0] wr_addr,
    input  sxd_pkg::row_t             wr_data
);
    import sxd_pkg::*;

    row_t                     mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] valid_reg;
    row_t                     data_reg;
    logic                     hit_reg;

    // row storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a row never written since reset reads as blank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read, same-row write in the same cycle is forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_reg <= (wr_en && (wr_addr == rd_addr)) || valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                data_reg <= wr_data;
            end
            else
            begin
                data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

// ----- test/sprite_xor_draw_with_collision_tb.sv -----
// self-checking testbench for the sprite row xor draw block with collision flag
`default_nettype none

module sprite_xor_draw_with_collision_tb;

    import sxd_pkg::*;

    localparam int RAND_WORDS  = 650;
    localparam int STALL_LIMIT = 4000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct
    {
        cmd_word_t    word;
        bit           fixed;
        result_word_t want;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    cmd_word_t    cmd;
    logic         done;
    result_word_t result;

    // screen image and sprite collision flag as the block should hold them
    row_t         screen_img [SCREEN_HEIGHT];
    logic         collide_flag;

    result_word_t pending_results [$];
    dir_row_t     dir_tab [$];
    int           bad_words;
    int           stall_cycles;
    int           words_sent;

    sprite_xor_draw_with_collision u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // apply one command word to the screen image, return the expected result word
    task automatic run_screen_cmd(input cmd_word_t w, output result_word_t r);
        int row_sel;
        int col;
        int pix;
        r = '0;
        if (w.mode == MODE_DRAW)
        begin
            row_sel = (int'(w.sprite_y) + int'(w.row_index)) % SCREEN_HEIGHT;
            if (w.row_index == 4'd0)
                collide_flag = 1'b0;
            for (int b = 0; b < SPRITE_W; b++)
            begin
                if (w.row_pixels[SPRITE_W-1-b])
                begin
                    col = (int'(w.sprite_x) + b) % SCREEN_WIDTH;
                    if (screen_img[row_sel][col])
                        collide_flag = 1'b1;
                    screen_img[row_sel][col] = ~screen_img[row_sel][col];
                end
            end
        end
        else
        begin
            for (int b = 0; b < SPRITE_W; b++)
            begin
                pix = int'(w.byte_index) * SPRITE_W + b;
                if (pix < SCREEN_WIDTH * SCREEN_HEIGHT)
                    r.read_byte[SPRITE_W-1-b] = screen_img[pix / SCREEN_WIDTH][pix % SCREEN_WIDTH];
            end
        end
        r.collision = collide_flag;
    endtask

    function automatic cmd_word_t make_word(mode_t m, int x, int y, int ri, int px, int bi);
        cmd_word_t w;
        w.mode       = m;
        w.sprite_x   = 8'(x);
        w.sprite_y   = 8'(y);
        w.row_index  = 4'(ri);
        w.row_pixels = 8'(px);
        w.byte_index = 8'(bi);
        return w;
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        w.mode       = mode_t'($urandom_range(0, 1));
        w.sprite_x   = 8'($urandom_range(0, 255));
        w.sprite_y   = 8'($urandom_range(0, 255));
        w.row_index  = 4'($urandom_range(0, 15));
        w.row_pixels = 8'($urandom_range(0, 255));
        w.byte_index = 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic add_row(mode_t m, int x, int y, int ri, int px, int bi,
                           bit fixed, logic coll, logic [7:0] rb);
        dir_row_t d;
        d.word           = make_word(m, x, y, ri, px, bi);
        d.fixed          = fixed;
        d.want.collision = coll;
        d.want.read_byte = rb;
        dir_tab.push_back(d);
    endtask

    // drop start and put a random idle word on cmd
    task automatic hold_off();
        @(negedge clk);
        start <= 1'b0;
        cmd   <= random_word();
    endtask

    // offer one word until taken, then log what it should return
    task automatic send_word(input cmd_word_t w, input bit fixed, input result_word_t want,
                             input bit steady);
        result_word_t predicted;
        if (!steady)
            while ($urandom_range(0, 99) < 28)
                hold_off();
        @(negedge clk);
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        run_screen_cmd(w, predicted);
        pending_results.push_back(fixed ? want : predicted);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(string what, result_word_t want, result_word_t got);
        bad_words++;
        if (bad_words <= SHOW_LIMIT)
            $display("mismatch (%s): expected collision=%0d read_byte=%02h, got collision=%0d read_byte=%02h",
                     what, want.collision, want.read_byte, got.collision, got.read_byte);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                want = '0;
                flag_mismatch("result word with nothing pending", want, result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.collision != want.collision)
                    flag_mismatch("collision", want, result);
                else if (result.read_byte != want.read_byte)
                    flag_mismatch("read_byte", want, result);
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        result_word_t none;
        cmd_word_t    w;
        int           kind;
        int           rows;
        int           x0;
        int           y0;
        bit           drained;
        bit           steady;

        none         = '0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        bad_words    = 0;
        stall_cycles = 0;
        words_sent   = 0;
        collide_flag = 1'b0;
        for (int r = 0; r < SCREEN_HEIGHT; r++)
            screen_img[r] = '0;

        // directed table: extremes, both modes, wrap, row fifteen, collision clear
        add_row(MODE_READ, 0,   0,   0,  8'h00, 0,   1, 1'b0, 8'h00);
        add_row(MODE_READ, 0,   0,   0,  8'h00, 255, 1, 1'b0, 8'h00);
        add_row(MODE_DRAW, 0,   0,   0,  8'hFF, 0,   1, 1'b0, 8'h00);
        add_row(MODE_READ, 0,   0,   0,  8'h00, 0,   1, 1'b0, 8'hFF);
        add_row(MODE_DRAW, 0,   0,   0,  8'h80, 0,   1, 1'b1, 8'h00);
        add_row(MODE_READ, 0,   0,   0,  8'h00, 0,   1, 1'b1, 8'h7F);
        add_row(MODE_DRAW, 255, 255, 15, 8'hFF, 0,   1, 1'b1, 8'h00);
        add_row(MODE_READ, 0,   0,   0,  8'h00, 119, 1, 1'b1, 8'h01);
        add_row(MODE_READ, 0,   0,   0,  8'h00, 112, 1, 1'b1, 8'hFE);
        add_row(MODE_DRAW, 60,  31,  1,  8'hAA, 0,   0, 1'b0, 8'h00);
        add_row(MODE_DRAW, 10,  10,  0,  8'h00, 0,   1, 1'b0, 8'h00);
        add_row(MODE_READ, 0,   0,   0,  8'h00, 7,   0, 1'b0, 8'h00);
        add_row(MODE_DRAW, 0,   0,   0,  8'h40, 0,   1, 1'b1, 8'h00);
        add_row(MODE_READ, 255, 255, 15, 8'hFF, 0,   0, 1'b0, 8'h00);
        add_row(MODE_DRAW, 63,  0,   5,  8'h00, 255, 0, 1'b0, 8'h00);
        add_row(MODE_DRAW, 63,  32,  2,  8'h01, 255, 0, 1'b0, 8'h00);
        add_row(MODE_DRAW, 128, 64,  14, 8'h81, 170, 0, 1'b0, 8'h00);
        add_row(MODE_READ, 0,   0,   0,  8'h00, 128, 0, 1'b0, 8'h00);
        add_row(MODE_DRAW, 255, 255, 15, 8'hFF, 0,   0, 1'b0, 8'h00);
        add_row(MODE_READ, 0,   0,   0,  8'h00, 119, 0, 1'b0, 8'h00);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
            send_word(dir_tab[i].word, dir_tab[i].fixed, dir_tab[i].want, 1'b0);

        // random part: mostly whole sprites, plus reads and loose noise
        words_sent = 0;
        drained    = 1'b0;
        while (words_sent < RAND_WORDS)
        begin
            steady = (words_sent >= 250 && words_sent < 400);
            if (!drained && words_sent >= 450)
            begin
                drain_results();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                rows = $urandom_range(1, 16);
                if ($urandom_range(0, 3) == 0)
                begin
                    x0 = $urandom_range(0, 7);
                    y0 = $urandom_range(0, 7);
                end
                else
                begin
                    x0 = $urandom_range(0, 255);
                    y0 = $urandom_range(0, 255);
                end
                for (int r = 0; r < rows; r++)
                begin
                    w = random_word();
                    w.mode      = MODE_DRAW;
                    w.sprite_x  = 8'(x0);
                    w.sprite_y  = 8'(y0);
                    w.row_index = 4'(r);
                    send_word(w, 1'b0, none, steady);
                end
            end
            else if (kind < 80)
            begin
                w = random_word();
                w.mode = MODE_READ;
                send_word(w, 1'b0, none, steady);
            end
            else
                send_word(random_word(), 1'b0, none, steady);
        end

        // wind down
        drain_results();
        repeat (8) @(posedge clk);
        if (bad_words == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
